// ===== rtl/evad_pkg.sv =====
package evad_pkg;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MARGIN   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONSET    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HANGOVER = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOORMIN = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FALL     = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RISE     = 8'd5;

  localparam logic [17:0] DB_PER_OCTAVE = 18'd197283;

  typedef struct packed {
    logic [13:0] margin_db;
    logic [7:0]  onset_frames;
    logic [15:0] hold_frames;
    logic [14:0] floor_min_db;
    logic [15:0] floor_fall;
    logic [13:0] floor_rise_step;
  } cfg_t;

  typedef struct packed {
    logic        speech;
    logic        loud;
    logic [14:0] level_db;
    logic [14:0] floor_db;
  } res_t;

  function automatic logic [16:0] log2_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:  v = 17'd0;
      5'd1:  v = 17'd5732;
      5'd2:  v = 17'd11136;
      5'd3:  v = 17'd16248;
      5'd4:  v = 17'd21098;
      5'd5:  v = 17'd25711;
      5'd6:  v = 17'd30109;
      5'd7:  v = 17'd34312;
      5'd8:  v = 17'd38336;
      5'd9:  v = 17'd42196;
      5'd10: v = 17'd45904;
      5'd11: v = 17'd49472;
      5'd12: v = 17'd52911;
      5'd13: v = 17'd56229;
      5'd14: v = 17'd59434;
      5'd15: v = 17'd62534;
      5'd16: v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/evad_if.sv =====
interface evad_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last_in_frame;
  modport source (output valid, sample, last_in_frame, input ready);
  modport sink (input valid, sample, last_in_frame, output ready);
endinterface

interface evad_out_if;
  logic        valid;
  logic        ready;
  logic        speech;
  logic        loud;
  logic [14:0] level_db;
  logic [14:0] floor_db;
  modport source (output valid, speech, loud, level_db, floor_db, input ready);
  modport sink (input valid, speech, loud, level_db, floor_db, output ready);
endinterface

interface evad_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [evad_pkg::CFG_IDX_W-1:0] index;
  logic [evad_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/evad_front.sv =====
module evad_front #(
  parameter int MAX_FRAME = 1024,
  parameter int CW        = 11,
  parameter int SW        = 27,
  parameter int QW        = 41
) (
  input  logic              clk,
  input  logic              rst_n,
  evad_in_if.sink           in_word,
  input  logic              q_full,
  output logic              q_push,
  output logic [CW+SW+QW-1:0] q_data
);

  logic [CW-1:0]        count_r, count_nxt, count_inc;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic [QW-1:0]        sq_r, sq_nxt;
  logic signed [31:0]   sq_full;
  logic [30:0]          sq_u;
  logic                 accept, close;

  assign in_word.ready = !q_full;
  assign accept        = in_word.valid && in_word.ready;
  assign sq_full       = in_word.sample * in_word.sample;
  assign sq_u          = sq_full[30:0];
  assign count_inc     = count_r + CW'(1);
  assign close         = in_word.last_in_frame || (count_inc == CW'(MAX_FRAME));
  assign sum_nxt       = sum_r + SW'(in_word.sample);
  assign sq_nxt        = sq_r + QW'(sq_u);
  assign count_nxt     = close ? '0 : count_inc;
  assign q_push        = accept && close;
  assign q_data        = {count_inc, sum_nxt, sq_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
      sum_r   <= close ? '0 : sum_nxt;
      sq_r    <= close ? '0 : sq_nxt;
    end
  end

endmodule

// ===== rtl/evad_fifo.sv =====
module evad_fifo #(
  parameter int DW = 79
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          full,
  output logic          empty
);

  logic [DW-1:0] mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/evad_back.sv =====
module evad_back #(
  parameter int CW = 11,
  parameter int SW = 27,
  parameter int QW = 41
) (
  input  logic                clk,
  input  logic                rst_n,
  input  evad_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  logic [CW+SW+QW-1:0] q_data,
  output logic                q_pop,
  input  logic                out_ready,
  output logic                out_valid,
  output evad_pkg::res_t      out_res
);

  localparam int NQW = CW + QW;
  localparam int SSW = 2 * (SW - 1);
  localparam int DW  = NQW + 8;
  localparam int NNW = 2 * CW;
  localparam int XW  = DW + 1;
  localparam int KW  = $clog2(DW + 1);
  localparam int PW  = $clog2(XW);
  localparam int LW  = PW + 17;
  localparam int MW  = LW + 18;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_SUB  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_NORM = 4'd4;
  localparam logic [3:0] S_LOG  = 4'd5;
  localparam logic [3:0] S_DB   = 4'd6;
  localparam logic [3:0] S_DEC  = 4'd7;
  localparam logic [3:0] S_FLR  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]           st_r;
  logic [CW-1:0]        n_r;
  logic signed [SW-1:0] s_r;
  logic [QW-1:0]        q_r;
  logic [NQW-1:0]       nq_r;
  logic [SSW-1:0]       ss_r;
  logic [NNW-1:0]       nn_r;
  logic [DW-1:0]        dvd_r;
  logic [NNW-1:0]       rem_r;
  logic [KW-1:0]        k_r;
  logic [XW-1:0]        x_r;
  logic [PW-1:0]        p_r;
  logic [LW-1:0]        l2_r;
  logic [14:0]          level_r;
  logic [14:0]          fl_r;
  logic                 down_r, loud_r;
  logic [30:0]          dn_r;
  logic [14:0]          up_r;

  logic                 primed_r, speech_r;
  logic [7:0]           run_r;
  logic [15:0]          hang_r;
  logic [14:0]          floor_r;
  logic                 ov_r;
  evad_pkg::res_t       res_r;

  logic [SW-2:0]        s_abs;
  logic [NNW:0]         trial;
  logic                 qbit;
  logic [14:0]          frac;
  logic [16:0]          t0, t1, tdiff, l2f;
  logic [27:0]          ip;
  logic [MW-1:0]        dbp;
  logic [MW-25:0]       dbs;
  logic [14:0]          fl_cur;
  logic                 loud_c;
  logic [7:0]           run_nxt;
  logic                 speech_nxt;
  logic [15:0]          hang_nxt;
  logic [13:0]          step;
  logic [14:0]          gap_up;
  logic [15:0]          dec;
  logic [15:0]          fl_new;

  logic [SW-1:0]        s_neg;
  assign s_neg  = -s_r;
  assign s_abs  = s_r[SW-1] ? s_neg[SW-2:0] : s_r[SW-2:0];
  assign trial  = {rem_r, dvd_r[DW-1]};
  assign qbit   = trial >= {1'b0, nn_r};
  assign frac   = x_r[XW-2 -: 15];
  assign t0     = evad_pkg::log2_tab({1'b0, frac[14:11]});
  assign t1     = evad_pkg::log2_tab({1'b0, frac[14:11]} + 5'd1);
  assign tdiff  = t1 - t0;
  assign ip     = 28'(tdiff[13:0]) * 28'(frac[10:0]);
  assign l2f    = t0 + {6'd0, ip[21:11]} + {ip[27:22], 11'd0};
  assign dbp    = MW'(l2_r) * MW'(evad_pkg::DB_PER_OCTAVE) + (MW'(1) << 23);
  assign dbs    = dbp[MW-1:24];

  assign fl_cur     = primed_r ? floor_r
                    : ((level_r < cfg.floor_min_db) ? cfg.floor_min_db : level_r);
  assign loud_c     = {1'b0, level_r} > ({1'b0, fl_cur} + {2'b00, cfg.margin_db});
  assign run_nxt    = loud_c ? ((run_r == 8'd255) ? 8'd255 : run_r + 8'd1) : 8'd0;
  assign speech_nxt = (run_nxt >= cfg.onset_frames) ? 1'b1
                    : ((hang_r != 16'd0) ? speech_r : 1'b0);
  assign hang_nxt   = (run_nxt >= cfg.onset_frames) ? cfg.hold_frames
                    : ((hang_r != 16'd0) ? hang_r - 16'd1 : hang_r);
  assign step       = speech_nxt ? {2'b00, cfg.floor_rise_step[13:2]} : cfg.floor_rise_step;
  assign gap_up     = level_r - fl_cur;

  assign dec    = 16'(({1'b0, dn_r} + 32'd32768) >> 16);
  assign fl_new = down_r ? ({1'b0, fl_r} - dec) : ({1'b0, fl_r} + {1'b0, up_r});

  assign q_pop     = (st_r == S_IDLE) && !q_empty;
  assign out_valid = ov_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        {n_r, s_r, q_r} <= q_data;
      end
      S_MUL: begin
        nq_r <= NQW'(n_r) * NQW'(q_r);
        ss_r <= SSW'(s_abs) * SSW'(s_abs);
        nn_r <= NNW'(n_r) * NNW'(n_r);
      end
      S_SUB: begin
        dvd_r <= (nq_r > NQW'(ss_r)) ? {nq_r - NQW'(ss_r), 8'd0} : '0;
        rem_r <= '0;
      end
      S_DIV: begin
        dvd_r <= {dvd_r[DW-2:0], qbit};
        rem_r <= qbit ? NNW'(trial - {1'b0, nn_r}) : trial[NNW-1:0];
        x_r   <= XW'({dvd_r[DW-2:0], qbit}) + XW'(256);
        p_r   <= PW'(XW - 1);
      end
      S_NORM: begin
        if (!x_r[XW-1]) begin
          x_r <= {x_r[XW-2:0], 1'b0};
          p_r <= p_r - PW'(1);
        end
      end
      S_LOG: begin
        l2_r <= ((LW'(p_r) - LW'(8)) << 16) + LW'(l2f);
      end
      S_DB: begin
        level_r <= (dbs > (MW-24)'(32767)) ? 15'd32767 : dbs[14:0];
      end
      S_DEC: begin
        fl_r   <= fl_cur;
        loud_r <= loud_c;
        down_r <= level_r < fl_cur;
        dn_r   <= 31'(fl_cur - level_r) * 31'(cfg.floor_fall);
        up_r   <= (gap_up < {1'b0, step}) ? gap_up : {1'b0, step};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      k_r      <= '0;
      primed_r <= 1'b0;
      speech_r <= 1'b0;
      run_r    <= '0;
      hang_r   <= '0;
      floor_r  <= '0;
      ov_r     <= 1'b0;
      res_r    <= '0;
    end else begin
      if (ov_r && out_ready && (st_r != S_OUT)) begin
        ov_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (!q_empty) begin
            st_r <= S_MUL;
          end
        end
        S_MUL: st_r <= S_SUB;
        S_SUB: begin
          k_r  <= '0;
          st_r <= S_DIV;
        end
        S_DIV: begin
          k_r <= k_r + KW'(1);
          if (k_r == KW'(DW - 1)) begin
            st_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (x_r[XW-1]) begin
            st_r <= S_LOG;
          end
        end
        S_LOG: st_r <= S_DB;
        S_DB:  st_r <= S_DEC;
        S_DEC: begin
          primed_r <= 1'b1;
          run_r    <= run_nxt;
          speech_r <= speech_nxt;
          hang_r   <= hang_nxt;
          st_r     <= S_FLR;
        end
        S_FLR: begin
          floor_r <= (fl_new < {1'b0, cfg.floor_min_db}) ? cfg.floor_min_db : fl_new[14:0];
          st_r    <= S_OUT;
        end
        S_OUT: begin
          if (!ov_r || out_ready) begin
            ov_r           <= 1'b1;
            res_r.speech   <= speech_r;
            res_r.loud     <= loud_r;
            res_r.level_db <= level_r;
            res_r.floor_db <= floor_r;
            st_r           <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/energy_voice_activity_detector.sv =====
// Energy voice activity detector. Samples are taken one word per cycle; a
// frame closes on last_in_frame or on its MAX_FRAME-th sample, and one result
// word per frame follows. Frame-end work runs on a sequential back end: a
// restoring divider of CW+QW+8 bits, a one-bit-per-cycle normalizer, then
// log, decision and floor update, one frame at a time. A two-frame queue sits
// between sample intake and the back end, so intake stalls only when two closed
// frames are still waiting. Result words are held in an output register;
// configuration writes are always taken.
module energy_voice_activity_detector #(
  parameter int MAX_FRAME = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  evad_in_if.sink     in_word,
  evad_out_if.source  out_word,
  evad_cfg_if.sink    cfg_word
);

  localparam int LG = $clog2(MAX_FRAME);
  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam int SW = 17 + LG;
  localparam int QW = 31 + LG;
  localparam int FW = CW + SW + QW;

  evad_pkg::cfg_t cfg_r;
  evad_pkg::res_t res;
  logic           q_push, q_pop, q_full, q_empty;
  logic [FW-1:0]  q_wdata, q_rdata;

  assign cfg_word.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.margin_db       <= 14'd1536;
      cfg_r.onset_frames    <= 8'd3;
      cfg_r.hold_frames     <= 16'd25;
      cfg_r.floor_min_db    <= 15'd7680;
      cfg_r.floor_fall      <= 16'd6554;
      cfg_r.floor_rise_step <= 14'd13;
    end else if (cfg_word.valid) begin
      case (cfg_word.index)
        evad_pkg::REG_MARGIN:   cfg_r.margin_db       <= cfg_word.data[13:0];
        evad_pkg::REG_ONSET:    cfg_r.onset_frames    <= cfg_word.data[7:0];
        evad_pkg::REG_HANGOVER: cfg_r.hold_frames     <= cfg_word.data;
        evad_pkg::REG_FLOORMIN: cfg_r.floor_min_db    <= cfg_word.data[14:0];
        evad_pkg::REG_FALL:     cfg_r.floor_fall      <= cfg_word.data;
        evad_pkg::REG_RISE:     cfg_r.floor_rise_step <= cfg_word.data[13:0];
        default: begin
        end
      endcase
    end
  end

  evad_front #(.MAX_FRAME(MAX_FRAME), .CW(CW), .SW(SW), .QW(QW)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  evad_fifo #(.DW(FW)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  evad_back #(.CW(CW), .SW(SW), .QW(QW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_ready (out_word.ready),
    .out_valid (out_word.valid),
    .out_res   (res)
  );

  assign out_word.speech   = res.speech;
  assign out_word.loud     = res.loud;
  assign out_word.level_db = res.level_db;
  assign out_word.floor_db = res.floor_db;

endmodule

// ===== rtl/evad_checker.sv =====
module evad_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_speech,
  input logic        out_loud,
  input logic [14:0] out_level_db,
  input logic [14:0] out_floor_db,
  input logic        cfg_ready
);

  a_out_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result word valid right after reset");

  a_in_open_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready) else $error("sample intake closed after reset");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready) else $error("configuration port not ready");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_speech) && $stable(out_loud)
      && $stable(out_level_db) && $stable(out_floor_db))
    else $error("stalled result word changed");

endmodule

bind energy_voice_activity_detector evad_checker u_evad_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_word.ready),
  .out_valid    (out_word.valid),
  .out_ready    (out_word.ready),
  .out_speech   (out_word.speech),
  .out_loud     (out_word.loud),
  .out_level_db (out_word.level_db),
  .out_floor_db (out_word.floor_db),
  .cfg_ready    (cfg_word.ready)
);
